>>> rtl/hair_cell_transmitter_model_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hair cell transmitter model
// ----------------------------------------------------------------------------
`ifndef HAIR_CELL_TRANSMITTER_MODEL_DEFINES_SVH
`define HAIR_CELL_TRANSMITTER_MODEL_DEFINES_SVH

// same-cycle implication, checked on clk with async reset low masking
`define HCTM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hctm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctm_pkg
// Types and constants shared by the hair cell transmitter model.
// ----------------------------------------------------------------------------
package hctm_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERM_RATE      = 3'd0,
		REG_REPLENISH_RATE = 3'd1,
		REG_LOSS_RATE      = 3'd2,
		REG_REUPTAKE_RATE  = 3'd3,
		REG_REPROCESS_RATE = 3'd4,
		REG_SUBTRACT_SPONT = 3'd5,
		REG_SPONT_OFFSET   = 3'd6
	} cfg_reg_t;

	localparam logic [31:0] RST_PERM_RATE      = 32'd134217728;
	localparam logic [31:0] RST_REPLENISH_RATE = 32'd338900;
	localparam logic [31:0] RST_LOSS_RATE      = 32'd167772160;
	localparam logic [31:0] RST_REUPTAKE_RATE  = 32'd441576325;
	localparam logic [31:0] RST_REPROCESS_RATE = 32'd4449989;
	localparam logic [31:0] RST_SPONT_OFFSET   = 32'd85;

	// resting pool contents, Q0.32
	localparam logic [31:0] RST_FREE_POOL      = 32'd1540757012;
	localparam logic [31:0] RST_CLEFT_POOL     = 32'd5563505;
	localparam logic [31:0] RST_REPROCESS_POOL = 32'd552071526;

	// stimulus offset 5 and half saturation 300, both Q.19
	localparam logic signed [24:0] STIM_OFFSET = 25'sd2621440;
	localparam logic [28:0]        HALF_SAT    = 29'd157286400;
	localparam logic [32:0]        OUT_GAIN    = 33'd50000;

	localparam int DIV_BITS = 32;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_KT,
		S_REP,
		S_EJ,
		S_LOSS,
		S_REUP,
		S_REPR,
		S_UPD,
		S_WB,
		S_RESP,
		S_OUT
	} hctm_state_t;

	typedef struct packed {
		logic        start;
		logic [23:0] st;
	} div_ctl_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quot;
	} div_sts_t;

	function automatic logic [31:0] sat_pool(input logic signed [37:0] v);
		logic [31:0] r;
		if (v < 38'sd0) begin
			r = 32'd0;
		end else if (v > 38'sh0_FFFF_FFFF) begin
			r = 32'hFFFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/hctm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctm_in_if
// Input item channel: channel index and stimulus sample.
// ----------------------------------------------------------------------------
interface hctm_in_if;
	logic               valid;
	logic               ready;
	logic [5:0]         channel;
	logic signed [23:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

>>> rtl/hctm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctm_out_if
// Result item channel: channel index and response.
// ----------------------------------------------------------------------------
interface hctm_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  channel_out;
	logic [31:0] response;

	modport source (output valid, output channel_out, output response, input ready);
	modport sink   (input valid, input channel_out, input response, output ready);
endinterface

>>> rtl/hctm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hctm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/hctm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctm_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module hctm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/hctm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hctm_div
// Restoring divider: quot = floor(st * 2^32 / (st + HALF_SAT)), one bit a cycle.
// ----------------------------------------------------------------------------
module hctm_div
	import hctm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_ctl_t ctl,
	output div_sts_t sts
);
	logic [28:0] rem_q;
	logic [28:0] den_q;
	logic [31:0] quot_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [29:0] shifted;
	logic        take;

	// remainder stays below the divisor, so the doubled value fits 30 bits
	assign shifted = {rem_q, 1'b0};
	assign take    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= {5'd0, ctl.st};
			den_q  <= {5'd0, ctl.st} + HALF_SAT;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? 29'(shifted - {1'b0, den_q}) : shifted[28:0];
			quot_q <= {quot_q[30:0], take};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quot = quot_q;
endmodule

>>> rtl/hair_cell_transmitter_model.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hair_cell_transmitter_model
// Inner hair cell transmitter pools per channel, one sample at a time.
// ----------------------------------------------------------------------------
// From acceptance to result an item goes through the bit-serial permeability
// divider, then seven passes through the single shared 32x33 multiplier
// (permeability, five flows, response) plus the pool update and write-back.
// The pools of all channels sit in one RAM; per-channel valid flops make an
// unwritten channel read as the resting pool values. An item whose channel
// is not below CHANNELS gives response 0 and leaves the pools alone. The
// block takes no new item until its result is loaded into the output
// register; register writes are accepted every cycle.
`include "hair_cell_transmitter_model_defines.svh"

module hair_cell_transmitter_model
	import hctm_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic clk,
	input  logic arst_n,
	hctm_in_if.sink   in_ch,
	hctm_out_if.source out_ch,
	hctm_cfg_if.sink  cfg
);
	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = (AW > 6) ? AW : 6;

	hctm_state_t state_q, state_d;

	logic [31:0] perm_q, repl_rate_q, loss_rate_q, reup_rate_q, repr_rate_q, spont_q;
	logic        sub_spont_q;

	logic [CHANNELS-1:0] vld_q;
	logic                rvld_q;
	logic [5:0]          ch_q;
	logic                bad_q;
	logic [AW-1:0]       addr_q;

	logic [95:0] ram_rdata;
	logic [95:0] ram_wdata;
	logic        ram_we;

	logic [31:0] pool_q, pool_c, pool_w;
	logic [31:0] kt_q;
	logic [33:0] rep_q, ej_q, loss_q, reup_q, repr_q;
	logic [31:0] cnew_q;

	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic        mul_en;
	logic [64:0] prod_q;
	logic [33:0] flow_res;

	logic        out_valid_q;
	logic [5:0]  ch_out_q;
	logic [31:0] resp_q;
	logic        out_load;
	logic        in_acc;
	logic        ch_ok;
	logic [CW-1:0] chx;

	logic signed [24:0] st_raw;
	div_ctl_t div_ctl;
	div_sts_t div_sts;

	logic signed [37:0] free_new, cleft_new, store_new;
	logic [31:0] resp_raw, resp_fin;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign chx = CW'(in_ch.channel);
	assign ch_ok = ({26'd0, in_ch.channel} < 32'(CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_q      <= RST_PERM_RATE;
			repl_rate_q <= RST_REPLENISH_RATE;
			loss_rate_q <= RST_LOSS_RATE;
			reup_rate_q <= RST_REUPTAKE_RATE;
			repr_rate_q <= RST_REPROCESS_RATE;
			sub_spont_q <= 1'b0;
			spont_q     <= RST_SPONT_OFFSET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PERM_RATE:      perm_q      <= cfg.data;
				REG_REPLENISH_RATE: repl_rate_q <= cfg.data;
				REG_LOSS_RATE:      loss_rate_q <= cfg.data;
				REG_REUPTAKE_RATE:  reup_rate_q <= cfg.data;
				REG_REPROCESS_RATE: repr_rate_q <= cfg.data;
				REG_SUBTRACT_SPONT: sub_spont_q <= cfg.data[0];
				REG_SPONT_OFFSET:   spont_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// stimulus offset and clamp at zero
	assign st_raw = 25'(in_ch.sample) + STIM_OFFSET;
	assign div_ctl.start = in_acc && ch_ok;
	assign div_ctl.st = st_raw[24] ? 24'd0 : st_raw[23:0];

	hctm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	hctm_ram #(
		.WIDTH (96),
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_pools (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (chx[AW-1:0]),
		.rdata (ram_rdata)
	);

	// never-written channels read as resting values
	assign pool_q = rvld_q ? ram_rdata[95:64] : RST_FREE_POOL;
	assign pool_c = rvld_q ? ram_rdata[63:32] : RST_CLEFT_POOL;
	assign pool_w = rvld_q ? ram_rdata[31:0]  : RST_REPROCESS_POOL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q   <= in_ch.channel;
			bad_q  <= !ch_ok;
			addr_q <= chx[AW-1:0];
			rvld_q <= ch_ok ? vld_q[chx[AW-1:0]] : 1'b0;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_KT: begin
				mul_a = perm_q;
				mul_b = {1'b0, div_sts.quot};
			end
			S_REP: begin
				mul_a = repl_rate_q;
				mul_b = 33'h1_0000_0000 - {1'b0, pool_q};
			end
			S_EJ: begin
				mul_a = kt_q;
				mul_b = {1'b0, pool_q};
			end
			S_LOSS: begin
				mul_a = loss_rate_q;
				mul_b = {1'b0, pool_c};
			end
			S_REUP: begin
				mul_a = reup_rate_q;
				mul_b = {1'b0, pool_c};
			end
			S_REPR: begin
				mul_a = repr_rate_q;
				mul_b = {1'b0, pool_w};
			end
			S_RESP: begin
				mul_a = cnew_q;
				mul_b = OUT_GAIN;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign flow_res = prod_q[63:30];

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= {33'd0, mul_a} * {32'd0, mul_b};
		end
		case (state_q)
			S_REP:  kt_q   <= prod_q[63:32];
			S_EJ:   rep_q  <= flow_res;
			S_LOSS: ej_q   <= flow_res;
			S_REUP: loss_q <= flow_res;
			S_REPR: reup_q <= flow_res;
			S_UPD:  repr_q <= flow_res;
			S_WB:   cnew_q <= sat_pool(cleft_new);
			default: ;
		endcase
	end

	assign free_new  = 38'(pool_q) + 38'(rep_q) - 38'(ej_q) + 38'(repr_q);
	assign cleft_new = 38'(pool_c) + 38'(ej_q) - 38'(loss_q) - 38'(reup_q);
	assign store_new = 38'(pool_w) + 38'(reup_q) - 38'(repr_q);

	assign ram_we    = (state_q == S_WB);
	assign ram_wdata = {sat_pool(free_new), sat_pool(cleft_new), sat_pool(store_new)};

	// 50000 * pool < 2^48, so the shifted product always fits
	assign resp_raw = prod_q[47:16];
	always_comb begin
		if (bad_q) begin
			resp_fin = '0;
		end else if (sub_spont_q) begin
			resp_fin = (resp_raw > spont_q) ? resp_raw - spont_q : 32'd0;
		end else begin
			resp_fin = resp_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = ch_ok ? S_DIV : S_OUT;
				end
			end
			S_DIV: begin
				if (div_sts.done) begin
					state_d = S_KT;
				end
			end
			S_KT:   state_d = S_REP;
			S_REP:  state_d = S_EJ;
			S_EJ:   state_d = S_LOSS;
			S_LOSS: state_d = S_REUP;
			S_REUP: state_d = S_REPR;
			S_REPR: state_d = S_UPD;
			S_UPD:  state_d = S_WB;
			S_WB:   state_d = S_RESP;
			S_RESP: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ch_out_q <= ch_q;
			resp_q   <= resp_fin;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.channel_out = ch_out_q;
	assign out_ch.response    = resp_q;

	`HCTM_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready, "block ready right after accept")
	`HCTM_ASSERT_NOW(a_no_wb_bad_ch, state_q == S_WB, !bad_q, "pool write for invalid channel")
	`HCTM_ASSERT_NOW(a_div_done_in_div, div_sts.done, state_q == S_DIV, "divider done outside divide")
	`HCTM_ASSERT_NEXT(a_load_shows, out_load, out_ch.valid, "loaded result not presented")
endmodule

>>> sim/hair_cell_transmitter_model_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hair_cell_transmitter_model_chk
// Watches the sample, result and register channels, keeps its own copy of
// the pools and registers, predicts each response and compares in order.
// ----------------------------------------------------------------------------
module hair_cell_transmitter_model_chk
	import hctm_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	hctm_in_if.sink    in_mon,
	hctm_out_if.sink   out_mon,
	hctm_cfg_if.sink   cfg_mon,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [5:0]  channel;
		logic [31:0] response;
	} hc_result_t;

	logic [31:0] perm_rate, repl_rate, loss_rate, reup_rate, repr_rate, spont_lvl;
	logic        spont_on;
	logic [31:0] free_q [CHANNELS];
	logic [31:0] cleft_q [CHANNELS];
	logic [31:0] store_q [CHANNELS];
	hc_result_t  expected_responses [$];

	function automatic logic [33:0] pool_flow(input logic [31:0] rate, input logic [63:0] opnd);
		logic [95:0] p;
		p = {64'd0, rate} * {32'd0, opnd};
		return p[63:30];
	endfunction

	function automatic logic [31:0] clamp_pool(input logic signed [39:0] v);
		if (v < 0) return 32'd0;
		if (v > 40'sh00_FFFF_FFFF) return 32'hFFFF_FFFF;
		return v[31:0];
	endfunction

	task automatic predict_sample(input logic [5:0] ch, input logic signed [23:0] smp);
		hc_result_t r;
		logic signed [25:0] st;
		logic [63:0] ratio, kt, resp;
		logic [31:0] q, c, w;
		logic [33:0] rep, ej, ls, ru, rp;
		r.channel = ch;
		r.response = 32'd0;
		if (ch < CHANNELS) begin
			st = 26'(smp) + 26'(STIM_OFFSET);
			if (st < 0) st = 0;
			ratio = ({38'd0, st[25:0]} << 32) / (64'(st) + 64'(HALF_SAT));
			kt = (64'(perm_rate) * ratio) >> 32;
			q = free_q[ch];
			c = cleft_q[ch];
			w = store_q[ch];
			rep = pool_flow(repl_rate, 64'h1_0000_0000 - 64'(q));
			ej = pool_flow(kt[31:0], 64'(q));
			ls = pool_flow(loss_rate, 64'(c));
			ru = pool_flow(reup_rate, 64'(c));
			rp = pool_flow(repr_rate, 64'(w));
			free_q[ch] = clamp_pool(40'(q) + 40'(rep) - 40'(ej) + 40'(rp));
			cleft_q[ch] = clamp_pool(40'(c) + 40'(ej) - 40'(ls) - 40'(ru));
			store_q[ch] = clamp_pool(40'(w) + 40'(ru) - 40'(rp));
			resp = (64'(OUT_GAIN) * 64'(cleft_q[ch])) >> 16;
			if (resp > 64'hFFFF_FFFF) resp = 64'hFFFF_FFFF;
			if (spont_on) resp = (resp > 64'(spont_lvl)) ? resp - 64'(spont_lvl) : 64'd0;
			r.response = resp[31:0];
		end
		expected_responses.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		hc_result_t e;
		if (!arst_n) begin
			perm_rate <= RST_PERM_RATE;
			repl_rate <= RST_REPLENISH_RATE;
			loss_rate <= RST_LOSS_RATE;
			reup_rate <= RST_REUPTAKE_RATE;
			repr_rate <= RST_REPROCESS_RATE;
			spont_lvl <= RST_SPONT_OFFSET;
			spont_on <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				free_q[i] = RST_FREE_POOL;
				cleft_q[i] = RST_CLEFT_POOL;
				store_q[i] = RST_REPROCESS_POOL;
			end
			expected_responses.delete();
			fail_count <= 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_reg_t'(cfg_mon.index))
				REG_PERM_RATE: perm_rate <= cfg_mon.data;
				REG_REPLENISH_RATE: repl_rate <= cfg_mon.data;
				REG_LOSS_RATE: loss_rate <= cfg_mon.data;
				REG_REUPTAKE_RATE: reup_rate <= cfg_mon.data;
				REG_REPROCESS_RATE: repr_rate <= cfg_mon.data;
				REG_SUBTRACT_SPONT: spont_on <= cfg_mon.data[0];
				REG_SPONT_OFFSET: spont_lvl <= cfg_mon.data;
				default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				predict_sample(in_mon.channel, in_mon.sample);
			if (out_mon.valid && out_mon.ready) begin
				if (expected_responses.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result ch=%0d resp=%h",
							out_mon.channel_out, out_mon.response);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_responses.pop_front();
					if (e.channel !== out_mon.channel_out || e.response !== out_mon.response) begin
						if (fail_count < 10)
							$display("mismatch: exp ch=%0d resp=%h, got ch=%0d resp=%h",
								e.channel, e.response, out_mon.channel_out, out_mon.response);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = expected_responses.size();

endmodule

>>> sim/hair_cell_transmitter_model_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hair_cell_transmitter_model_tb
// Drives register writes, and samples with random gaps, under random output
// stalls; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module hair_cell_transmitter_model_tb;
	import hctm_pkg::*;

	localparam int CHANNELS = 64;
	localparam int STALL_LIMIT = 20000;

	logic clk, arst_n;
	int   fail_count, pending, idle_cycles;
	bit   calm_phase, long_hold, hold_done;

	hctm_in_if  in_ch ();
	hctm_out_if out_ch ();
	hctm_cfg_if cfg ();

	hair_cell_transmitter_model #(.CHANNELS(CHANNELS)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

	hair_cell_transmitter_model_chk #(.CHANNELS(CHANNELS)) chk (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stall bursts, one long hold, none in the last part
	initial begin
		int n;
		out_ch.ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_done = 1'b1;
				out_ch.ready <= 1'b1;
			end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 9);
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// valid stays up after an accept; the next call drives the next item, or drain() takes it down
	task automatic send_sample(input logic [5:0] ch, input logic signed [23:0] smp);
		if (!calm_phase && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.channel <= ch;
		in_ch.sample <= smp;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// full-scale extremes, samples near the offset boundary and random samples
	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(0, 5))
		0: return 24'sh800000;
		1: return 24'sh7FFFFF;
		2: return 24'($urandom_range(0, 32'h7FFFFF)) - 24'sd2621440 + 24'sd2621440;
		3: return -24'sd2621440 + 24'($urandom_range(0, 2000));
		default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [5:0] pick_channel();
		if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, 7));
	endfunction

	initial begin
		logic [31:0] rates [5];
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.channel = '0;
		in_ch.sample = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		calm_phase = 1'b0;
		long_hold = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: sample extremes, offset boundary, channel extremes
		send_sample(6'd0, 24'sh800000);
		send_sample(6'd0, 24'sh7FFFFF);
		send_sample(6'd63, 24'sd0);
		send_sample(6'd1, -24'sd2621440);
		send_sample(6'd1, -24'sd2621439);
		send_sample(6'd2, 24'shFFFFFF);
		send_sample(6'd2, 24'sh555555);
		send_sample(6'd2, 24'shAAAAAA);
		for (int i = 0; i < 8; i++) send_sample(6'd3, 24'sh7FFFFF);
		drain();
		// spontaneous subtraction, huge offset clamps to zero
		write_reg(REG_SUBTRACT_SPONT, 32'd1);
		write_reg(REG_SPONT_OFFSET, 32'hFFFF_FFFF);
		send_sample(6'd4, 24'sd100000);
		drain();
		write_reg(REG_SPONT_OFFSET, 32'd0);
		send_sample(6'd4, 24'sd100000);
		drain();
		// extreme rates drive pool saturation both ways
		write_reg(REG_PERM_RATE, 32'hFFFF_FFFF);
		write_reg(REG_REPLENISH_RATE, 32'hFFFF_FFFF);
		write_reg(REG_REPROCESS_RATE, 32'hFFFF_FFFF);
		write_reg(REG_LOSS_RATE, 32'd0);
		write_reg(REG_REUPTAKE_RATE, 32'd0);
		write_reg(3'd7, 32'h1234_5678);
		for (int i = 0; i < 5; i++) send_sample(6'd5, 24'sh7FFFFF);
		drain();
		write_reg(REG_LOSS_RATE, 32'hFFFF_FFFF);
		write_reg(REG_REUPTAKE_RATE, 32'hFFFF_FFFF);
		write_reg(REG_PERM_RATE, 32'd0);
		for (int i = 0; i < 4; i++) send_sample(6'd5, 24'sd0);
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 5; r++)
				rates[r] = (ph == 0) ? 32'd0 : ($urandom_range(0, 3) == 0)
					? $urandom() : 32'($urandom_range(0, 32'h2000_0000));
			if (ph == 7) begin
				rates[0] = RST_PERM_RATE; rates[1] = RST_REPLENISH_RATE;
				rates[2] = RST_LOSS_RATE; rates[3] = RST_REUPTAKE_RATE;
				rates[4] = RST_REPROCESS_RATE;
			end
			write_reg(REG_PERM_RATE, rates[0]);
			write_reg(REG_REPLENISH_RATE, rates[1]);
			write_reg(REG_LOSS_RATE, rates[2]);
			write_reg(REG_REUPTAKE_RATE, rates[3]);
			write_reg(REG_REPROCESS_RATE, rates[4]);
			write_reg(REG_SUBTRACT_SPONT, 32'(ph[0]));
			write_reg(REG_SPONT_OFFSET, $urandom_range(0, 3) == 0 ? $urandom()
				: 32'($urandom_range(0, 20000)));
			if (ph == 7) calm_phase = 1'b1;
			if (ph == 3) long_hold = 1'b1;
			for (int i = 0; i < 103; i++) send_sample(pick_channel(), pick_sample());
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hctm_pkg.sv
rtl/hctm_in_if.sv
rtl/hctm_out_if.sv
rtl/hctm_cfg_if.sv
rtl/hctm_ram.sv
rtl/hctm_div.sv
rtl/hair_cell_transmitter_model.sv
sim/hair_cell_transmitter_model_chk.sv
sim/hair_cell_transmitter_model_tb.sv
